/* hw/rtl/rcwed_pkg.sv */
// shared constants and types of the roi color window event detector
// depends on nothing; imported by the top level and its checker

package rcwed_pkg;

    localparam int DEF_MAX_REGION_PIXELS = 4096;
    localparam int DEF_HISTORY_DEPTH     = 16;
    localparam int DEF_FRACTION_BITS     = 8;

    localparam int PIX_W      = 8;
    localparam int PIX_MAX    = (1 << PIX_W) - 1;
    localparam int TIME_W     = 24;
    localparam int COUNT_W    = 16;
    localparam int SMOOTH_W   = 5;
    localparam int NUM_CH     = 3;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [23:0]         RST_RED_THR     = 24'd9866882;
    localparam logic [15:0]         RST_GREEN_WIN   = 16'd35960;
    localparam logic [15:0]         RST_BLUE_WIN    = 16'd29545;
    localparam logic [SMOOTH_W-1:0] RST_SMOOTH      = 5'd10;
    localparam logic [TIME_W-1:0]   RST_OPEN_TIME   = 24'd8060;
    localparam logic [TIME_W-1:0]   RST_CLOSE_TIME  = 24'd388860;
    localparam logic [TIME_W-1:0]   RST_DISP_OFFSET = 24'd8110;

    typedef enum logic [2:0] {
        REG_RED_THR     = 3'd0,
        REG_GREEN_WIN   = 3'd1,
        REG_BLUE_WIN    = 3'd2,
        REG_SMOOTH      = 3'd3,
        REG_OPEN_TIME   = 3'd4,
        REG_CLOSE_TIME  = 3'd5,
        REG_DISP_OFFSET = 3'd6
    } reg_idx_t;

endpackage

/* hw/rtl/rcwed_ram.sv */
// generic single-clock ram, one write port and one registered read port
// no dependencies

module rcwed_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/roi_color_window_event_detector.sv */
// top level of the roi color window event detector
// depends on rcwed_pkg and rcwed_ram (frame mean history)
//
// Usage:
//   Input channel (in_valid/in_ready): one region pixel per item with
//   last_of_frame and frame_time_ms. Pixels that are not last are taken one
//   per cycle and only update the per-frame sums; they give no result.
//   After the last pixel of a frame the block drops in_ready while it
//   divides the sums (one quotient bit per cycle, all three channels at once),
//   writes the means to the history ram, reads back the history_fill newest
//   entries (one ram read a cycle), divides the rounded sum by the fill count
//   and tests the color windows. Each division yields SUM_W + FRACTION_BITS
//   quotient bits, 28 at the default parameters, and in_ready returns in the
//   cycle in which the result appears.
//   Output channel (out_valid/out_ready): one item per frame, held in an
//   output register. Pixels of the next frame are taken while it waits;
//   a stalled receiver only holds the block when the next frame closes.
//   Configuration: apb port, register i at byte address 4*i, pready always
//   high; write only while the block is idle.
//   Reset: asynchronous, clears sums, history pointer and fill, latch and
//   counter, and loads the default register values; the ram needs no clear.

module roi_color_window_event_detector
    import rcwed_pkg::*;
#(
    parameter int MAX_REGION_PIXELS = DEF_MAX_REGION_PIXELS,
    parameter int HISTORY_DEPTH     = DEF_HISTORY_DEPTH,
    parameter int FRACTION_BITS     = DEF_FRACTION_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [PIX_W-1:0]      red,
    input  logic [PIX_W-1:0]      green,
    input  logic [PIX_W-1:0]      blue,
    input  logic                  last_of_frame,
    input  logic [TIME_W-1:0]     frame_time_ms,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic [PIX_W-1:0]      smoothed_red,
    output logic [PIX_W-1:0]      smoothed_green,
    output logic [PIX_W-1:0]      smoothed_blue,
    output logic                  evaluating,
    output logic                  event_fired,
    output logic [COUNT_W-1:0]    event_total,
    output logic [TIME_W-1:0]     event_time_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W  = $clog2(MAX_REGION_PIXELS + 1);
    localparam int SUM_W  = $clog2(MAX_REGION_PIXELS * PIX_MAX + 1);
    localparam int MEAN_W = PIX_W + FRACTION_BITS;
    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int K_W    = $clog2(HISTORY_DEPTH + 1);
    localparam int ACC_W  = MEAN_W + K_W;
    localparam int DVD_W  = SUM_W + FRACTION_BITS;
    localparam int DV_W   = (CNT_W > K_W) ? CNT_W : K_W;
    localparam int ITER_W = $clog2(DVD_W);
    localparam int MEM_W  = NUM_CH * MEAN_W;

    typedef enum logic [6:0] {
        S_ACC    = 7'b0000001,
        S_DIV1   = 7'b0000010,
        S_WR     = 7'b0000100,
        S_RD     = 7'b0001000,
        S_RDWAIT = 7'b0010000,
        S_DIV2   = 7'b0100000,
        S_EVAL   = 7'b1000000
    } state_t;

    state_t state_reg;

    logic [23:0]         red_thr_reg;
    logic [15:0]         green_win_reg;
    logic [15:0]         blue_win_reg;
    logic [SMOOTH_W-1:0] smooth_reg;
    logic [TIME_W-1:0]   open_time_reg;
    logic [TIME_W-1:0]   close_time_reg;
    logic [TIME_W-1:0]   disp_offset_reg;

    logic [SUM_W-1:0]  sum_reg [NUM_CH];
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [K_W-1:0]    fill_reg;
    logic              latch_reg;
    logic [COUNT_W-1:0] counter_reg;

    logic [DVD_W-1:0]  dvd_reg [NUM_CH];
    logic [DV_W-1:0]   rem_reg [NUM_CH];
    logic [DV_W-1:0]   dvs_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [ACC_W-1:0]  acc_reg [NUM_CH];
    logic [PTR_W-1:0]  rd_addr_reg;
    logic [K_W-1:0]    rd_cnt_reg;
    logic              rd_pend_reg;
    logic [TIME_W-1:0] time_reg;

    logic               out_valid_reg;
    logic [PIX_W-1:0]   smoothed_red_reg;
    logic [PIX_W-1:0]   smoothed_green_reg;
    logic [PIX_W-1:0]   smoothed_blue_reg;
    logic               evaluating_reg;
    logic               event_fired_reg;
    logic [TIME_W-1:0]  event_time_reg;

    logic [PIX_W-1:0]  pix [NUM_CH];
    logic [SUM_W-1:0]  sum_add [NUM_CH];
    logic [CNT_W-1:0]  count_add;
    logic              count_room;
    logic [DV_W:0]     rem_sh [NUM_CH];
    logic              step_ge [NUM_CH];
    logic [DV_W-1:0]   rem_next [NUM_CH];
    logic [DVD_W-1:0]  dvd_next [NUM_CH];
    logic [ACC_W-1:0]  acc_add [NUM_CH];
    logic [K_W-1:0]    k_eff;
    logic              in_fire;
    logic              cfg_wr;
    logic              result_fire;
    logic              iter_done;

    logic              mem_we;
    logic [MEM_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [MEM_W-1:0]  mem_rdata;

    logic [PIX_W-1:0]  sr, sg, sb;
    logic              win_open;
    logic              red_in;
    logic              color_match;

    assign pix[0] = red;
    assign pix[1] = green;
    assign pix[2] = blue;

    assign in_ready    = (state_reg == S_ACC);
    assign in_fire     = in_valid && in_ready;
    assign cfg_wr      = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign result_fire = (state_reg == S_EVAL) && (!out_valid_reg || out_ready);
    assign iter_done   = (iter_reg == ITER_W'(DVD_W - 1));
    assign count_room  = (count_reg < CNT_W'(MAX_REGION_PIXELS));
    assign count_add   = count_room ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_add[c]  = count_room ? sum_reg[c] + SUM_W'(pix[c]) : sum_reg[c];
            rem_sh[c]   = {rem_reg[c], dvd_reg[c][DVD_W-1]};
            step_ge[c]  = (rem_sh[c] >= {1'b0, dvs_reg});
            rem_next[c] = step_ge[c] ? DV_W'(rem_sh[c] - {1'b0, dvs_reg})
                                     : rem_sh[c][DV_W-1:0];
            dvd_next[c] = {dvd_reg[c][DVD_W-2:0], step_ge[c]};
            acc_add[c]  = acc_reg[c] + (rd_pend_reg ?
                          ACC_W'(mem_rdata[c*MEAN_W +: MEAN_W]) : ACC_W'(0));
        end
    end

    always_comb
    begin
        if (smooth_reg == '0)
        begin
            k_eff = K_W'(1);
        end
        else if (int'(smooth_reg) > HISTORY_DEPTH)
        begin
            k_eff = K_W'(HISTORY_DEPTH);
        end
        else
        begin
            k_eff = K_W'(smooth_reg);
        end
    end

    // history ram
    assign mem_we    = (state_reg == S_WR);
    assign mem_wdata = {dvd_reg[2][MEAN_W-1:0], dvd_reg[1][MEAN_W-1:0],
                        dvd_reg[0][MEAN_W-1:0]};
    assign mem_re    = (state_reg == S_RD);

    rcwed_ram #(
        .WIDTH (MEM_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ptr_reg),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    // event rule
    assign sr = dvd_reg[0][PIX_W-1:0];
    assign sg = dvd_reg[1][PIX_W-1:0];
    assign sb = dvd_reg[2][PIX_W-1:0];

    assign win_open    = (time_reg > open_time_reg) && (time_reg < close_time_reg);
    assign red_in      = (sr >= red_thr_reg[7:0]) && (sr <= red_thr_reg[23:16]);
    assign color_match = !latch_reg && (sr < red_thr_reg[15:8])
                         && (sg >= green_win_reg[7:0]) && (sg <= green_win_reg[15:8])
                         && (sb >= blue_win_reg[7:0]) && (sb <= blue_win_reg[15:8]);

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_ACC;
            red_thr_reg     <= RST_RED_THR;
            green_win_reg   <= RST_GREEN_WIN;
            blue_win_reg    <= RST_BLUE_WIN;
            smooth_reg      <= RST_SMOOTH;
            open_time_reg   <= RST_OPEN_TIME;
            close_time_reg  <= RST_CLOSE_TIME;
            disp_offset_reg <= RST_DISP_OFFSET;
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum_reg[c] <= '0;
            end
            count_reg     <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            latch_reg     <= 1'b0;
            counter_reg   <= '0;
            iter_reg      <= '0;
            rd_cnt_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (reg_idx_t'(paddr[4:2]))
                    REG_RED_THR:     red_thr_reg     <= pwdata[23:0];
                    REG_GREEN_WIN:   green_win_reg   <= pwdata[15:0];
                    REG_BLUE_WIN:    blue_win_reg    <= pwdata[15:0];
                    REG_SMOOTH:      smooth_reg      <= pwdata[SMOOTH_W-1:0];
                    REG_OPEN_TIME:   open_time_reg   <= pwdata[TIME_W-1:0];
                    REG_CLOSE_TIME:  close_time_reg  <= pwdata[TIME_W-1:0];
                    REG_DISP_OFFSET: disp_offset_reg <= pwdata[TIME_W-1:0];
                    default:         ;
                endcase
            end

            if (out_valid_reg && out_ready && !result_fire)
            begin
                out_valid_reg <= 1'b0;
            end

            rd_pend_reg <= mem_re;

            case (state_reg)
                S_ACC:
                begin
                    if (in_fire)
                    begin
                        if (last_of_frame)
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                            begin
                                sum_reg[c] <= '0;
                            end
                            count_reg <= '0;
                            fill_reg  <= (fill_reg >= k_eff) ? k_eff : fill_reg + K_W'(1);
                            iter_reg  <= '0;
                            state_reg <= S_DIV1;
                        end
                        else
                        begin
                            for (int c = 0; c < NUM_CH; c++)
                            begin
                                sum_reg[c] <= sum_add[c];
                            end
                            count_reg <= count_add;
                        end
                    end
                end
                S_DIV1:
                begin
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_done)
                    begin
                        state_reg <= S_WR;
                    end
                end
                S_WR:
                begin
                    ptr_reg    <= (ptr_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0
                                                                          : ptr_reg + PTR_W'(1);
                    rd_cnt_reg <= '0;
                    state_reg  <= S_RD;
                end
                S_RD:
                begin
                    rd_cnt_reg <= rd_cnt_reg + K_W'(1);
                    if (rd_cnt_reg + K_W'(1) == fill_reg)
                    begin
                        state_reg <= S_RDWAIT;
                    end
                end
                S_RDWAIT:
                begin
                    iter_reg  <= '0;
                    state_reg <= S_DIV2;
                end
                S_DIV2:
                begin
                    iter_reg <= iter_reg + ITER_W'(1);
                    if (iter_done)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (result_fire)
                    begin
                        out_valid_reg <= 1'b1;
                        if (win_open)
                        begin
                            if (red_in)
                            begin
                                if (color_match)
                                begin
                                    latch_reg <= 1'b1;
                                    if (counter_reg != {COUNT_W{1'b1}})
                                    begin
                                        counter_reg <= counter_reg + COUNT_W'(1);
                                    end
                                end
                            end
                            else
                            begin
                                latch_reg <= 1'b0;
                            end
                        end
                        state_reg <= S_ACC;
                    end
                end
                default:
                begin
                    state_reg <= S_ACC;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_ACC:
            begin
                if (in_fire && last_of_frame)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        dvd_reg[c] <= {sum_add[c], {FRACTION_BITS{1'b0}}};
                        rem_reg[c] <= '0;
                    end
                    dvs_reg  <= DV_W'(count_add);
                    time_reg <= frame_time_ms;
                end
            end
            S_DIV1, S_DIV2:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    dvd_reg[c] <= dvd_next[c];
                    rem_reg[c] <= rem_next[c];
                end
            end
            S_WR:
            begin
                // rounding term, half of one unit per averaged frame
                for (int c = 0; c < NUM_CH; c++)
                begin
                    acc_reg[c] <= ACC_W'(fill_reg) << (FRACTION_BITS - 1);
                end
                rd_addr_reg <= ptr_reg;
            end
            S_RD:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    acc_reg[c] <= acc_add[c];
                end
                rd_addr_reg <= (rd_addr_reg == '0) ? PTR_W'(HISTORY_DEPTH - 1)
                                                   : rd_addr_reg - PTR_W'(1);
            end
            S_RDWAIT:
            begin
                for (int c = 0; c < NUM_CH; c++)
                begin
                    dvd_reg[c] <= DVD_W'(acc_add[c][ACC_W-1:FRACTION_BITS]);
                    rem_reg[c] <= '0;
                end
                dvs_reg <= DV_W'(fill_reg);
            end
            S_EVAL:
            begin
                if (result_fire)
                begin
                    smoothed_red_reg   <= sr;
                    smoothed_green_reg <= sg;
                    smoothed_blue_reg  <= sb;
                    evaluating_reg     <= win_open;
                    event_fired_reg    <= win_open && red_in && color_match;
                    event_time_reg     <= (time_reg > disp_offset_reg) ?
                                          time_reg - disp_offset_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // register readback
    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_RED_THR:     prdata = APB_DATA_W'(red_thr_reg);
            REG_GREEN_WIN:   prdata = APB_DATA_W'(green_win_reg);
            REG_BLUE_WIN:    prdata = APB_DATA_W'(blue_win_reg);
            REG_SMOOTH:      prdata = APB_DATA_W'(smooth_reg);
            REG_OPEN_TIME:   prdata = APB_DATA_W'(open_time_reg);
            REG_CLOSE_TIME:  prdata = APB_DATA_W'(close_time_reg);
            REG_DISP_OFFSET: prdata = APB_DATA_W'(disp_offset_reg);
            default:         prdata = '0;
        endcase
    end

    assign out_valid      = out_valid_reg;
    assign smoothed_red   = smoothed_red_reg;
    assign smoothed_green = smoothed_green_reg;
    assign smoothed_blue  = smoothed_blue_reg;
    assign evaluating     = evaluating_reg;
    assign event_fired    = event_fired_reg;
    assign event_total    = counter_reg;
    assign event_time_ms  = event_time_reg;

endmodule

/* hw/rtl/rcwed_checker.sv */
// port-level assertions of the roi color window event detector
// depends on rcwed_pkg; bound to roi_color_window_event_detector

module rcwed_checker
    import rcwed_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               last_of_frame,
    input logic               out_valid,
    input logic               out_ready,
    input logic [PIX_W-1:0]   smoothed_red,
    input logic [PIX_W-1:0]   smoothed_green,
    input logic [PIX_W-1:0]   smoothed_blue,
    input logic               evaluating,
    input logic               event_fired,
    input logic [COUNT_W-1:0] event_total,
    input logic [TIME_W-1:0]  event_time_ms
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(smoothed_red)
        && $stable(smoothed_green) && $stable(smoothed_blue) && $stable(evaluating)
        && $stable(event_fired) && $stable(event_total) && $stable(event_time_ms))
        else $error("result item changed while stalled");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_of_frame |=> !in_ready)
        else $error("input taken while frame is being closed");

    a_result_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result item appeared outside frame processing");

    a_fire_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_fired |-> evaluating)
        else $error("event fired outside evaluation window");

    a_fire_counts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_fired |-> event_total != '0)
        else $error("event fired with zero event total");

endmodule

bind roi_color_window_event_detector rcwed_checker u_rcwed_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .last_of_frame  (last_of_frame),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smoothed_red   (smoothed_red),
    .smoothed_green (smoothed_green),
    .smoothed_blue  (smoothed_blue),
    .evaluating     (evaluating),
    .event_fired    (event_fired),
    .event_total    (event_total),
    .event_time_ms  (event_time_ms)
);
